// File: hw/rtl/alle_pkg.sv
`timescale 1ns / 1ps

package alle_pkg;

    // node store geometry, tied to the 5-bit signed head field
    localparam int IDX_W      = 4;
    localparam int NODES      = 2 ** IDX_W;
    localparam int MAX_OUT    = 16;
    localparam int READ_LIMIT = (NODES < MAX_OUT) ? NODES : MAX_OUT;
    localparam int STEP_W     = IDX_W + 1;

    // field widths
    localparam int OP_W   = 3;
    localparam int HEAD_W = 5;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;

    // stream packing
    localparam int IN_W      = 40;
    localparam int OUT_USED  = HEAD_W + VAL_W + STAT_W;
    localparam int OUT_W     = 40;
    localparam int OUT_PAD_W = OUT_W - OUT_USED;

    // link: node index or none
    typedef struct packed {
        logic             nil;
        logic [IDX_W-1:0] idx;
    } link_t;

    localparam link_t LINK_NONE = '{nil: 1'b1, idx: '0};

    typedef enum logic [OP_W-1:0] {
        OP_INS_FIRST  = 3'd0,
        OP_INS_LAST   = 3'd1,
        OP_INS_SORTED = 3'd2,
        OP_DELETE     = 3'd3,
        OP_READ       = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_WALK,
        S_WR1,
        S_WR2,
        S_EMIT,
        S_READ
    } state_t;

    // sequencer to node store
    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic             val_we;
        logic             link_we;
        logic [IDX_W-1:0] wr_addr;
        logic [VAL_W-1:0] wr_val;
        link_t            wr_link;
    } mem_req_t;

    // node store to sequencer, in the cycle after the read address
    typedef struct packed {
        logic [VAL_W-1:0] rd_val;
        link_t            rd_link;
    } mem_rsp_t;

    // port head to link, negative means empty
    function automatic link_t head_from_port(input logic [HEAD_W-1:0] h);
        link_t l;
        l.nil = h[HEAD_W-1];
        l.idx = h[IDX_W-1:0];
        return l;
    endfunction

    // link to port head, none becomes -1
    function automatic logic [HEAD_W-1:0] head_to_port(input link_t l);
        logic [HEAD_W-1:0] h;
        h = l.nil ? '1 : HEAD_W'(l.idx);
        return h;
    endfunction

    // link of an entry never written: i minus one, entry zero ends the free list
    function automatic link_t reset_link(input logic [IDX_W-1:0] a);
        link_t l;
        if (a == '0)
        begin
            l = LINK_NONE;
        end
        else
        begin
            l.nil = 1'b0;
            l.idx = a - IDX_W'(1);
        end
        return l;
    endfunction

endpackage

// File: hw/rtl/alle_node_mem.sv
`timescale 1ns / 1ps

module alle_node_mem (
    input  logic               clk,
    input  logic               rst_n,
    input  alle_pkg::mem_req_t req,
    output alle_pkg::mem_rsp_t rsp
);
    import alle_pkg::*;

    logic [VAL_W-1:0] val_mem  [NODES];
    link_t            link_mem [NODES];
    logic [NODES-1:0] written_reg;
    logic [VAL_W-1:0] rd_val_reg;
    link_t            rd_link_reg;
    logic             rd_written_reg;
    logic [IDX_W-1:0] rd_addr_reg;

    // value store, contents undefined until written
    always_ff @(posedge clk)
    begin
        if (req.val_we)
        begin
            val_mem[req.wr_addr] <= req.wr_val;
        end
        rd_val_reg <= val_mem[req.rd_addr];
    end

    // link store
    always_ff @(posedge clk)
    begin
        if (req.link_we)
        begin
            link_mem[req.wr_addr] <= req.wr_link;
        end
        rd_link_reg <= link_mem[req.rd_addr];
        rd_addr_reg <= req.rd_addr;
    end

    // per-entry written flags, cleared at reset so the free list is rebuilt at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (req.link_we)
            begin
                written_reg[req.wr_addr] <= 1'b1;
            end
            rd_written_reg <= written_reg[req.rd_addr];
        end
    end

    // unwritten links read as their reset value
    assign rsp.rd_val  = rd_val_reg;
    assign rsp.rd_link = rd_written_reg ? rd_link_reg : reset_link(rd_addr_reg);

endmodule

// File: hw/rtl/alle_seq.sv
`timescale 1ns / 1ps

module alle_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [alle_pkg::IN_W-1:0]   in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [alle_pkg::HEAD_W-1:0] out_head,
    output logic [alle_pkg::VAL_W-1:0]  out_value,
    output logic [alle_pkg::STAT_W-1:0] out_status,
    output logic                        out_last,
    output alle_pkg::mem_req_t          req,
    input  alle_pkg::mem_rsp_t          rsp
);
    import alle_pkg::*;

    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    link_t                   head_reg, head_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic [IDX_W-1:0]        n_reg, n_next;
    link_t                   cur_reg, cur_next;
    link_t                   prev_reg, prev_next;
    link_t                   nxt_reg, nxt_next;
    logic [STEP_W-1:0]       steps_reg, steps_next;
    link_t                   free_head_reg, free_head_next;
    status_t                 status_reg, status_next;

    logic                    out_valid_reg;
    logic [HEAD_W-1:0]       out_head_reg, out_head_next;
    logic [VAL_W-1:0]        out_value_reg, out_value_next;
    logic [STAT_W-1:0]       out_status_reg, out_status_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_load;
    logic                    out_free;

    op_t                     in_op;
    link_t                   in_head;
    logic signed [VAL_W-1:0] in_val;
    logic                    steps_ok;
    logic                    val_less;
    logic                    val_match;
    logic                    read_last;

    // input unpacking
    assign in_op   = op_t'(in_data[OP_W-1:0]);
    assign in_head = head_from_port(in_data[OP_W +: HEAD_W]);
    assign in_val  = $signed(in_data[OP_W+HEAD_W +: VAL_W]);

    // walk conditions on the node just read
    assign steps_ok  = steps_reg < STEP_W'(NODES);
    assign val_less  = $signed(rsp.rd_val) < val_reg;
    assign val_match = $signed(rsp.rd_val) == val_reg;
    assign read_last = rsp.rd_link.nil || ((steps_reg + STEP_W'(1)) >= STEP_W'(READ_LIMIT));

    assign out_free = !out_valid_reg || out_ready;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '{nil: 1'b0, idx: IDX_W'(NODES - 1)};
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            steps_reg     <= steps_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        head_reg   <= head_next;
        val_reg    <= val_next;
        n_reg      <= n_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        nxt_reg    <= nxt_next;
        status_reg <= status_next;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_head_reg   <= out_head_next;
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    // sequencer: allocate, walk, write back, emit, or read out a list
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        head_next       = head_reg;
        val_next        = val_reg;
        n_next          = n_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        nxt_next        = nxt_reg;
        steps_next      = steps_reg;
        free_head_next  = free_head_reg;
        status_next     = status_reg;
        in_ready        = 1'b0;
        out_load        = 1'b0;
        out_head_next   = head_to_port(head_reg);
        out_value_next  = '0;
        out_status_next = status_reg;
        out_last_next   = 1'b1;
        req             = '0;
        req.rd_addr     = cur_reg.idx;
        req.wr_addr     = n_reg;
        req.wr_val      = val_reg;
        req.wr_link     = LINK_NONE;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next     = in_op;
                    head_next   = in_head;
                    val_next    = in_val;
                    cur_next    = in_head;
                    prev_next   = LINK_NONE;
                    steps_next  = STEP_W'(1);
                    status_next = STAT_OK;
                    req.rd_addr = in_head.idx;
                    unique case (in_op)
                        OP_INS_FIRST, OP_INS_LAST, OP_INS_SORTED:
                        begin
                            if (free_head_reg.nil)
                            begin
                                status_next = STAT_FULL;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                n_next      = free_head_reg.idx;
                                req.rd_addr = free_head_reg.idx;
                                state_next  = S_ALLOC;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (in_head.nil)
                            begin
                                status_next = STAT_EMPTY;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        OP_READ:
                        begin
                            steps_next = '0;
                            if (in_head.nil)
                            begin
                                status_next = STAT_EMPTY;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end

            // pop the free list, start the walk where one is needed
            S_ALLOC:
            begin
                free_head_next = rsp.rd_link;
                req.rd_addr    = head_reg.idx;
                unique case (op_reg)
                    OP_INS_LAST:
                    begin
                        state_next = head_reg.nil ? S_WR1 : S_WALK;
                    end
                    OP_INS_SORTED:
                    begin
                        steps_next = '0;
                        state_next = head_reg.nil ? S_WR1 : S_WALK;
                    end
                    default:
                    begin
                        state_next = S_WR1;
                    end
                endcase
            end

            // one node per cycle, data of cur_reg is on the read port
            S_WALK:
            begin
                unique case (op_reg)
                    OP_INS_LAST:
                    begin
                        if (!rsp.rd_link.nil && steps_ok)
                        begin
                            cur_next    = rsp.rd_link;
                            steps_next  = steps_reg + STEP_W'(1);
                            req.rd_addr = rsp.rd_link.idx;
                        end
                        else
                        begin
                            state_next = S_WR1;
                        end
                    end
                    OP_INS_SORTED:
                    begin
                        if (steps_ok && val_less)
                        begin
                            prev_next   = cur_reg;
                            cur_next    = rsp.rd_link;
                            steps_next  = steps_reg + STEP_W'(1);
                            req.rd_addr = rsp.rd_link.idx;
                            if (rsp.rd_link.nil)
                            begin
                                state_next = S_WR1;
                            end
                        end
                        else
                        begin
                            state_next = S_WR1;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (!rsp.rd_link.nil && !val_match && steps_ok)
                        begin
                            prev_next   = cur_reg;
                            cur_next    = rsp.rd_link;
                            steps_next  = steps_reg + STEP_W'(1);
                            req.rd_addr = rsp.rd_link.idx;
                        end
                        else if (!val_match)
                        begin
                            status_next = STAT_NOT_FOUND;
                            state_next  = S_EMIT;
                        end
                        else
                        begin
                            nxt_next   = rsp.rd_link;
                            state_next = S_WR1;
                        end
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end

            // first write back
            S_WR1:
            begin
                state_next = S_EMIT;
                unique case (op_reg)
                    OP_INS_FIRST:
                    begin
                        req.val_we  = 1'b1;
                        req.link_we = 1'b1;
                        req.wr_link = head_reg;
                        head_next   = '{nil: 1'b0, idx: n_reg};
                    end
                    OP_INS_LAST:
                    begin
                        req.val_we  = 1'b1;
                        req.link_we = 1'b1;
                        if (head_reg.nil)
                        begin
                            head_next = '{nil: 1'b0, idx: n_reg};
                        end
                        else
                        begin
                            state_next = S_WR2;
                        end
                    end
                    OP_INS_SORTED:
                    begin
                        req.val_we  = 1'b1;
                        req.link_we = 1'b1;
                        req.wr_link = cur_reg;
                        if (prev_reg.nil)
                        begin
                            head_next = '{nil: 1'b0, idx: n_reg};
                        end
                        else
                        begin
                            state_next = S_WR2;
                        end
                    end
                    OP_DELETE:
                    begin
                        req.link_we    = 1'b1;
                        req.wr_addr    = cur_reg.idx;
                        req.wr_link    = free_head_reg;
                        free_head_next = cur_reg;
                        if (prev_reg.nil)
                        begin
                            head_next = nxt_reg;
                        end
                        else
                        begin
                            state_next = S_WR2;
                        end
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end

            // relink the predecessor or the tail
            S_WR2:
            begin
                state_next = S_EMIT;
                unique case (op_reg)
                    OP_INS_LAST:
                    begin
                        req.link_we = 1'b1;
                        req.wr_addr = cur_reg.idx;
                        req.wr_link = '{nil: 1'b0, idx: n_reg};
                    end
                    OP_INS_SORTED:
                    begin
                        req.link_we = 1'b1;
                        req.wr_addr = prev_reg.idx;
                        req.wr_link = '{nil: 1'b0, idx: n_reg};
                    end
                    OP_DELETE:
                    begin
                        req.link_we = 1'b1;
                        req.wr_addr = prev_reg.idx;
                        req.wr_link = nxt_reg;
                    end
                    default:
                    begin
                        req.link_we = 1'b0;
                    end
                endcase
            end

            // single result
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // one result per node, read address held while the output stalls
            S_READ:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_value_next  = rsp.rd_val;
                    out_status_next = STAT_OK;
                    out_last_next   = read_last;
                    if (read_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cur_next    = rsp.rd_link;
                        steps_next  = steps_reg + STEP_W'(1);
                        req.rd_addr = rsp.rd_link.idx;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_head   = out_head_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

    // walks never run past the node count
    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        steps_reg <= STEP_W'(NODES))
        else $error("walk step count beyond node count");

    // the store is only written during write back
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        (req.val_we || req.link_we) |-> (state_reg == S_WR1 || state_reg == S_WR2))
        else $error("node store written outside write back");

    // an accepted item always starts work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("accepted item left sequencer idle");

    // results come only from the emit or read states
    a_load_states: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (state_reg == S_EMIT || state_reg == S_READ))
        else $error("result loaded from wrong state");

endmodule

// File: hw/rtl/array_linked_list_engine.sv
`timescale 1ns / 1ps

// Linked-list engine over a 16-node store with a free list threaded through the links.
// Input stream: one item per operation (insert first, insert last, insert sorted,
// delete value, read list) on a caller-held list head. Output stream: one result per
// item, or one result per node for read list, with tlast on the final one.
// One item is worked on at a time; s_axis_tready is high while the sequencer is idle.
// Items that touch no node (store full, delete or read of an empty list, spare op codes)
// go straight to the result, insert first allocates a node and writes it back, and
// insert last, insert sorted and delete walk one node per cycle through the link store
// before writing back; read list gives one result per cycle, up to 16, while the output
// register is free or m_axis_tready is high.
// The walk is bound by the single read port of the node store, whose read is registered.
// At the earliest, m_axis_tvalid rises once the emit state has loaded the output register.
// A finished result waits in an output register, and the next item is taken meanwhile;
// while that register is full and m_axis_tready is low the sequencer holds its result and stalls.
// Reset empties the output and rebuilds the free list at once (node 15 down to node 0),
// so items are taken from the first cycle after reset.
module array_linked_list_engine (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [alle_pkg::IN_W-1:0]  s_axis_tdata,   // op[2:0], head_in[7:3], value_in[39:8]
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [alle_pkg::OUT_W-1:0] m_axis_tdata,   // head_out[4:0], value_out[36:5], status[38:37]
    output logic                       m_axis_tlast
);
    import alle_pkg::*;

    mem_req_t          req;
    mem_rsp_t          rsp;
    logic [HEAD_W-1:0] out_head;
    logic [VAL_W-1:0]  out_value;
    logic [STAT_W-1:0] out_status;

    // node value and link store
    alle_node_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // operation sequencer and result register
    alle_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_head   (out_head),
        .out_value  (out_value),
        .out_status (out_status),
        .out_last   (m_axis_tlast),
        .req        (req),
        .rsp        (rsp)
    );

    // result packing
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_status, out_value, out_head};

endmodule

// File: dv/array_linked_list_engine_checker.sv
`timescale 1ns / 1ps

module array_linked_list_engine_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [alle_pkg::IN_W-1:0]   s_axis_tdata,   // op[2:0], head_in[7:3], value_in[39:8]
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [alle_pkg::OUT_W-1:0]  m_axis_tdata,   // head_out[4:0], value_out[36:5], status[38:37]
    input  logic                        m_axis_tlast,
    output int                          mismatches,
    output int                          pending,
    output int                          checked,
    output int                          full_seen,
    output int                          miss_seen,
    output logic [alle_pkg::HEAD_W-1:0] head_now
);
    import alle_pkg::*;

    typedef struct packed {
        logic [HEAD_W-1:0] head;
        logic [VAL_W-1:0]  value;
        status_t           status;
        logic              last;
    } list_result_t;

    // shadow of the node store and free list
    logic signed [VAL_W-1:0] node_val [NODES];
    int                      node_nxt [NODES];
    int                      free_top;

    list_result_t            result_q [$];
    list_result_t            want;
    logic [HEAD_W-1:0]       got_head;
    logic [VAL_W-1:0]        got_val;
    logic [STAT_W-1:0]       got_stat;
    int                      fail_cnt;
    int                      seen_cnt;
    int                      full_cnt;
    int                      miss_cnt;

    function automatic bit in_store(input int i);
        return i >= 0 && i < NODES;
    endfunction

    task automatic queue_result(input int hd, input logic [VAL_W-1:0] v, input status_t st,
                                input logic fin);
        list_result_t r;
        r.head   = hd[HEAD_W-1:0];
        r.value  = v;
        r.status = st;
        r.last   = fin;
        result_q.push_back(r);
    endtask

    task automatic rebuild_store();
        for (int i = 0; i < NODES; i++)
        begin
            node_val[i] = '0;
            node_nxt[i] = i - 1;
        end
        free_top = NODES - 1;
        result_q.delete();
    endtask

    // apply one list operation, queue its results and return the new head
    task automatic run_list_op(input logic [OP_W-1:0] op, input logic [HEAD_W-1:0] head_bits,
                               input logic signed [VAL_W-1:0] v, output int hd);
        int  n;
        int  cur;
        int  prev;
        int  steps;
        int  nxt;
        int  k;
        logic fin;
        hd = $signed(head_bits);
        if (!in_store(hd))
            hd = -1;
        if (op == OP_INS_FIRST || op == OP_INS_LAST || op == OP_INS_SORTED)
        begin
            if (!in_store(free_top))
            begin
                queue_result(hd, '0, STAT_FULL, 1'b1);
                return;
            end
            n = free_top;
            free_top = node_nxt[n];
            if (op == OP_INS_FIRST)
            begin
                node_val[n] = v;
                node_nxt[n] = hd;
                hd = n;
            end
            else if (op == OP_INS_LAST)
            begin
                if (hd < 0)
                begin
                    node_val[n] = v;
                    node_nxt[n] = -1;
                    hd = n;
                end
                else
                begin
                    // find the tail before touching the new node
                    cur = hd;
                    steps = 1;
                    while (in_store(node_nxt[cur]) && steps < NODES)
                    begin
                        cur = node_nxt[cur];
                        steps++;
                    end
                    node_val[n] = v;
                    node_nxt[n] = -1;
                    node_nxt[cur] = n;
                end
            end
            else
            begin
                // stop at the first node not less than the new value
                prev = -1;
                cur = hd;
                steps = 0;
                while (in_store(cur) && steps < NODES && node_val[cur] < v)
                begin
                    prev = cur;
                    cur = node_nxt[cur];
                    steps++;
                end
                node_val[n] = v;
                node_nxt[n] = cur;
                if (prev < 0)
                    hd = n;
                else
                    node_nxt[prev] = n;
            end
            queue_result(hd, '0, STAT_OK, 1'b1);
        end
        else if (op == OP_DELETE)
        begin
            if (hd < 0)
            begin
                queue_result(hd, '0, STAT_EMPTY, 1'b1);
                return;
            end
            prev = -1;
            cur = hd;
            steps = 1;
            while (in_store(node_nxt[cur]) && node_val[cur] != v && steps < NODES)
            begin
                prev = cur;
                cur = node_nxt[cur];
                steps++;
            end
            if (node_val[cur] != v)
            begin
                queue_result(hd, '0, STAT_NOT_FOUND, 1'b1);
                return;
            end
            // unlink and push onto the free list
            nxt = node_nxt[cur];
            node_nxt[cur] = free_top;
            free_top = cur;
            if (prev < 0)
                hd = nxt;
            else
                node_nxt[prev] = nxt;
            queue_result(hd, '0, STAT_OK, 1'b1);
        end
        else if (op == OP_READ)
        begin
            if (hd < 0)
            begin
                queue_result(-1, '0, STAT_EMPTY, 1'b1);
                return;
            end
            cur = hd;
            k = 0;
            while (in_store(cur) && k < READ_LIMIT)
            begin
                nxt = node_nxt[cur];
                fin = !in_store(nxt) || (k + 1) >= READ_LIMIT;
                queue_result(hd, node_val[cur], STAT_OK, fin);
                k++;
                cur = nxt;
            end
        end
        else
        begin
            // spare op codes leave everything alone
            queue_result(hd, '0, STAT_OK, 1'b1);
        end
    endtask

    // compare results, then predict for a newly taken item
    always @(posedge clk or negedge rst_n)
    begin
        int new_head;
        if (!rst_n)
        begin
            rebuild_store();
            fail_cnt   = 0;
            seen_cnt   = 0;
            full_cnt   = 0;
            miss_cnt   = 0;
            mismatches <= 0;
            pending    <= 0;
            checked    <= 0;
            full_seen  <= 0;
            miss_seen  <= 0;
            head_now   <= '1;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_head = m_axis_tdata[4:0];
                got_val  = m_axis_tdata[36:5];
                got_stat = m_axis_tdata[38:37];
                if (result_q.size() == 0)
                begin
                    $error("unexpected result: head_out %0d value_out %0d status %0d last %0b",
                           $signed(got_head), $signed(got_val), got_stat, m_axis_tlast);
                    fail_cnt++;
                end
                else
                begin
                    want = result_q.pop_front();
                    seen_cnt++;
                    if (got_stat == STAT_FULL)
                        full_cnt++;
                    if (got_stat == STAT_NOT_FOUND)
                        miss_cnt++;
                    if (got_head !== want.head)
                    begin
                        $error("head_out: expected %0d, got %0d",
                               $signed(want.head), $signed(got_head));
                        fail_cnt++;
                    end
                    if (got_val !== want.value)
                    begin
                        $error("value_out: expected %0d, got %0d",
                               $signed(want.value), $signed(got_val));
                        fail_cnt++;
                    end
                    if (got_stat !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got_stat);
                        fail_cnt++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
                        fail_cnt++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                run_list_op(s_axis_tdata[2:0], s_axis_tdata[7:3], s_axis_tdata[39:8], new_head);
                head_now <= new_head[HEAD_W-1:0];
            end
            mismatches <= fail_cnt;
            pending    <= result_q.size();
            checked    <= seen_cnt;
            full_seen  <= full_cnt;
            miss_seen  <= miss_cnt;
        end
    end

endmodule

// File: dv/array_linked_list_engine_tb.sv
`timescale 1ns / 1ps

module array_linked_list_engine_tb;
    import alle_pkg::*;

    localparam int                CYCLE_LIMIT  = 200000;
    localparam int                HOLD_CYCLES  = 160;
    localparam int                RAND_ITEMS   = 245;
    localparam int                LISTS        = 3;
    localparam logic [HEAD_W-1:0] NO_HEAD      = 5'b11111;
    localparam logic [HEAD_W-1:0] BAD_HEAD     = 5'b10000;
    localparam logic [HEAD_W-1:0] SOME_HEAD    = 5'd3;
    localparam logic [OP_W-1:0]   OP_SPARE_LO  = 3'd5;
    localparam logic [OP_W-1:0]   OP_SPARE_HI  = 3'd7;
    localparam logic [VAL_W-1:0]  VAL_MIN      = 32'h8000_0000;
    localparam logic [VAL_W-1:0]  VAL_MAX      = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0]  VAL_ABSENT   = 32'h5555_5555;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              m_axis_tlast;

    int                mismatches;
    int                pending;
    int                checked;
    int                full_seen;
    int                miss_seen;
    logic [HEAD_W-1:0] head_now;

    int                items_sent;
    int                cycles;
    bit                calm;
    logic [HEAD_W-1:0] list_head [LISTS];
    logic [VAL_W-1:0]  value_pool [8];

    array_linked_list_engine uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    array_linked_list_engine_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .pending       (pending),
        .checked       (checked),
        .full_seen     (full_seen),
        .miss_seen     (miss_seen),
        .head_now      (head_now)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // offer one item, return at the falling edge after it is taken
    task automatic send_item(input logic [OP_W-1:0] op, input logic [HEAD_W-1:0] head,
                             input logic [VAL_W-1:0] value);
        while (!calm && $urandom_range(99) < 31)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, head, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // drop valid and wait for every outstanding result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // result side: random stalls, one long hold-off, a calm stretch
    initial
    begin
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (!held && items_sent >= 100)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else if (calm)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= 31);
        end
    end

    // stimulus and verdict
    initial
    begin
        int pick;
        int slot;
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] value;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        items_sent = 0;
        cycles = 0;
        calm = 1'b0;
        for (int i = 0; i < LISTS; i++)
            list_head[i] = NO_HEAD;
        value_pool[0] = VAL_MIN;
        value_pool[1] = VAL_MAX;
        value_pool[2] = '0;
        value_pool[3] = '1;
        for (int i = 4; i < 8; i++)
            value_pool[i] = $urandom;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty list and spare op corners
        send_item(OP_READ, NO_HEAD, '0);
        send_item(OP_DELETE, NO_HEAD, $urandom);
        send_item(OP_SPARE_HI, BAD_HEAD, $urandom);
        send_item(OP_SPARE_LO, SOME_HEAD, $urandom);

        // build one list until the store runs out, mixing the three inserts
        send_item(OP_INS_FIRST, BAD_HEAD, VAL_MIN);
        list_head[0] = head_now;
        send_item(OP_INS_LAST, list_head[0], VAL_MAX);
        send_item(OP_INS_SORTED, list_head[0], '0);
        send_item(OP_INS_SORTED, list_head[0], VAL_MIN);
        list_head[0] = head_now;
        send_item(OP_INS_SORTED, list_head[0], VAL_MAX);
        send_item(OP_INS_FIRST, list_head[0], '1);
        list_head[0] = head_now;
        for (int i = 1; i <= 10; i++)
        begin
            case (i % 3)
                0:       op = OP_INS_FIRST;
                1:       op = OP_INS_LAST;
                default: op = OP_INS_SORTED;
            endcase
            send_item(op, list_head[0], i * 32'h0101_0101);
            list_head[0] = head_now;
        end
        send_item(OP_INS_LAST, list_head[0], $urandom);

        // full read, then deletes: a miss and two nodes past the head
        send_item(OP_READ, list_head[0], '0);
        send_item(OP_DELETE, list_head[0], VAL_ABSENT);
        send_item(OP_DELETE, list_head[0], VAL_MIN);
        list_head[0] = head_now;
        send_item(OP_DELETE, list_head[0], VAL_MAX);
        list_head[0] = head_now;
        send_item(OP_READ, list_head[0], '0);

        // random: mostly operations on held lists, some noise with any head
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i == 60)
                drain_results();
            calm = (i >= 150 && i < 190);
            slot = $urandom_range(LISTS - 1);
            value = ($urandom_range(3) != 0) ? value_pool[$urandom_range(7)] : $urandom;
            if ($urandom_range(99) < 80)
            begin
                pick = $urandom_range(99);
                if (pick < 12)
                    op = OP_INS_FIRST;
                else if (pick < 24)
                    op = OP_INS_LAST;
                else if (pick < 40)
                    op = OP_INS_SORTED;
                else if (pick < 75)
                    op = OP_DELETE;
                else
                    op = OP_READ;
                send_item(op, list_head[slot], value);
                list_head[slot] = head_now;
            end
            else
            begin
                send_item(OP_W'($urandom_range(7)), HEAD_W'($urandom_range(31)), value);
                if ($urandom_range(3) == 0)
                    list_head[slot] = head_now;
            end
        end
        calm = 1'b0;

        drain_results();
        repeat (40) @(negedge clk);
        $display("%0d items sent over five list operations and spare codes, %0d results checked",
                 items_sent, checked);
        $display("store full %0d times, delete misses %0d, one %0d-cycle output hold-off",
                 full_seen, miss_seen, HOLD_CYCLES);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/alle_pkg.sv
hw/rtl/alle_node_mem.sv
hw/rtl/alle_seq.sv
hw/rtl/array_linked_list_engine.sv
dv/array_linked_list_engine_checker.sv
dv/array_linked_list_engine_tb.sv
